/* src/tlf_pkg.sv */
`default_nettype none
package tlf_pkg;

    // character codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_SP     = 8'd32;
    localparam logic [7:0] CH_HYPHEN = 8'd45;

    // line width register
    localparam logic [5:0] LINE_WIDTH_RST = 6'd63;
    localparam logic [5:0] MIN_WIDTH      = 6'd2;

    // status from the fold controller to the top level
    typedef struct packed {
        logic       busy;
        logic [5:0] fill;
    } fold_status_t;

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_NL);
    endfunction

endpackage
`default_nettype wire

/* src/tlf_ifs.sv */
`default_nettype none
// input byte channel
interface tlf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

// folded output channel
interface tlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       line_end;
    modport source (output valid, output out_char, output line_end, input ready);
    modport sink (input valid, input out_char, input line_end, output ready);
endinterface

// line width write channel
interface tlf_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] line_width;
    modport source (output valid, output line_width, input ready);
    modport sink (input valid, input line_width, output ready);
endinterface
`default_nettype wire

/* src/tlf_ram.sv */
`default_nettype none
module tlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule
`default_nettype wire

/* src/tlf_fold_ctrl.sv */
`default_nettype none
module tlf_fold_ctrl #(
    parameter int MAX_WIDTH = 63
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [5:0]                   width_eff,
    tlf_char_if.sink                          char_in,
    tlf_out_if.source                         char_out,
    output logic                              ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0]      ram_waddr,
    output logic [7:0]                        ram_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0]      ram_raddr,
    input  wire logic [7:0]                   ram_rdata,
    output tlf_pkg::fold_status_t             status
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EMIT   = 2'd1;
    localparam logic [1:0] S_COPY   = 2'd2;
    localparam logic [1:0] S_APPEND = 2'd3;

    logic [1:0]    state_reg, state_next;
    // line trackers: count, trimmed length, last word start, trimmed length before it
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] trim_reg, trim_next;
    logic [CW-1:0] wstart_reg, wstart_next;
    logic [CW-1:0] ptrim_reg, ptrim_next;
    logic          lastws_reg, lastws_next;
    // plan of the current emission
    logic [7:0]    char_reg, char_next;
    logic [CW-1:0] emit_len_reg, emit_len_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          hyph_reg, hyph_next;
    logic          fold_reg, fold_next;
    logic [CW-1:0] src_reg, src_next;
    logic [CW-1:0] clen_reg, clen_next;
    // carry copy
    logic [CW-1:0] cp_rd_reg, cp_rd_next;
    logic          cp_wp_reg, cp_wp_next;
    logic [AW-1:0] cp_wa_reg, cp_wa_next;
    // output register
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          out_end_reg, out_end_next;

    logic          slot_free;
    logic          fold;
    logic          single;
    logic [CW-1:0] last_idx;
    logic [CW-1:0] cp_src;
    logic [CW-1:0] b_fill, b_trim, b_wstart, b_ptrim;
    logic          b_lastws;
    logic          set_base;
    logic          do_upd;
    logic [7:0]    u_ch;

    assign slot_free = !out_valid_reg || char_out.ready;
    assign last_idx  = fill_reg - CW'(1);
    assign fold      = (fill_reg != '0) && !tlf_pkg::is_space(char_in.in_char) && !lastws_reg;
    assign single    = fold && (ptrim_reg == '0);
    assign cp_src    = src_reg + cp_rd_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        trim_next      = trim_reg;
        wstart_next    = wstart_reg;
        ptrim_next     = ptrim_reg;
        lastws_next    = lastws_reg;
        char_next      = char_reg;
        emit_len_next  = emit_len_reg;
        idx_next       = idx_reg;
        rd_pend_next   = rd_pend_reg;
        hyph_next      = hyph_reg;
        fold_next      = fold_reg;
        src_next       = src_reg;
        clen_next      = clen_reg;
        cp_rd_next     = cp_rd_reg;
        cp_wp_next     = cp_wp_reg;
        cp_wa_next     = cp_wa_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_end_next   = out_end_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = char_reg;
        ram_raddr      = '0;
        b_fill         = fill_reg;
        b_trim         = trim_reg;
        b_wstart       = wstart_reg;
        b_ptrim        = ptrim_reg;
        b_lastws       = lastws_reg;
        set_base       = 1'b0;
        do_upd         = 1'b0;
        u_ch           = char_in.in_char;

        // output beat taken
        if (out_valid_reg && char_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (char_in.valid)
                begin
                    if ((char_in.in_char != tlf_pkg::CH_NL) && (6'(fill_reg) < width_eff))
                    begin
                        // store the byte, line not full
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[AW-1:0];
                        ram_wdata = char_in.in_char;
                        do_upd    = 1'b1;
                    end
                    else
                    begin
                        // plan the line emission and carry
                        char_next    = char_in.in_char;
                        fold_next    = fold;
                        hyph_next    = single;
                        idx_next     = '0;
                        rd_pend_next = 1'b0;
                        if (single)
                        begin
                            emit_len_next = last_idx;
                            src_next      = last_idx;
                            clen_next     = CW'(1);
                        end
                        else if (fold)
                        begin
                            emit_len_next = ptrim_reg;
                            src_next      = wstart_reg;
                            clen_next     = fill_reg - wstart_reg;
                        end
                        else
                        begin
                            emit_len_next = trim_reg;
                            src_next      = '0;
                            clen_next     = '0;
                        end
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (rd_pend_reg)
                begin
                    // read data lands in the freed output register
                    out_valid_next = 1'b1;
                    out_char_next  = ram_rdata;
                    out_end_next   = 1'b0;
                    rd_pend_next   = 1'b0;
                end
                else if (slot_free)
                begin
                    if (idx_reg < emit_len_reg)
                    begin
                        ram_raddr    = idx_reg[AW-1:0];
                        idx_next     = idx_reg + CW'(1);
                        rd_pend_next = 1'b1;
                    end
                    else if (hyph_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = tlf_pkg::CH_HYPHEN;
                        out_end_next   = 1'b0;
                        hyph_next      = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = tlf_pkg::CH_NL;
                        out_end_next   = 1'b1;
                        cp_rd_next     = '0;
                        cp_wp_next     = 1'b0;
                        state_next     = S_COPY;
                    end
                end
            end

            S_COPY:
            begin
                // forward copy of the carried word to the line start
                if (cp_wp_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (cp_rd_reg < clen_reg)
                begin
                    ram_raddr  = cp_src[AW-1:0];
                    cp_rd_next = cp_rd_reg + CW'(1);
                    cp_wp_next = 1'b1;
                    cp_wa_next = cp_rd_reg[AW-1:0];
                end
                else
                begin
                    cp_wp_next = 1'b0;
                    if (!cp_wp_reg)
                    begin
                        state_next = S_APPEND;
                    end
                end
            end

            S_APPEND:
            begin
                // new line base, then the incoming byte
                set_base = 1'b1;
                if (fold_reg)
                begin
                    b_fill   = clen_reg;
                    b_trim   = clen_reg;
                    b_lastws = 1'b0;
                end
                else
                begin
                    b_fill   = '0;
                    b_trim   = '0;
                    b_lastws = 1'b1;
                end
                b_wstart = '0;
                b_ptrim  = '0;
                u_ch     = char_reg;
                if (char_reg != tlf_pkg::CH_NL)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = b_fill[AW-1:0];
                    ram_wdata = char_reg;
                    do_upd    = 1'b1;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (set_base)
        begin
            fill_next   = b_fill;
            trim_next   = b_trim;
            wstart_next = b_wstart;
            ptrim_next  = b_ptrim;
            lastws_next = b_lastws;
        end

        // tracker update for one appended byte
        if (do_upd)
        begin
            fill_next = b_fill + CW'(1);
            if (tlf_pkg::is_space(u_ch))
            begin
                lastws_next = 1'b1;
                trim_next   = b_trim;
                wstart_next = b_wstart;
                ptrim_next  = b_ptrim;
            end
            else
            begin
                lastws_next = 1'b0;
                trim_next   = b_fill + CW'(1);
                if (b_lastws)
                begin
                    wstart_next = b_fill;
                    ptrim_next  = b_trim;
                end
                else
                begin
                    wstart_next = b_wstart;
                    ptrim_next  = b_ptrim;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            trim_reg      <= '0;
            wstart_reg    <= '0;
            ptrim_reg     <= '0;
            lastws_reg    <= 1'b1;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hyph_reg      <= 1'b0;
            fold_reg      <= 1'b0;
            cp_rd_reg     <= '0;
            cp_wp_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            trim_reg      <= trim_next;
            wstart_reg    <= wstart_next;
            ptrim_reg     <= ptrim_next;
            lastws_reg    <= lastws_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            hyph_reg      <= hyph_next;
            fold_reg      <= fold_next;
            cp_rd_reg     <= cp_rd_next;
            cp_wp_reg     <= cp_wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        emit_len_reg <= emit_len_next;
        src_reg      <= src_next;
        clen_reg     <= clen_next;
        cp_wa_reg    <= cp_wa_next;
        out_char_reg <= out_char_next;
        out_end_reg  <= out_end_next;
    end

    assign char_in.ready     = (state_reg == S_IDLE);
    assign char_out.valid    = out_valid_reg;
    assign char_out.out_char = out_char_reg;
    assign char_out.line_end = out_end_reg;
    assign status.busy       = (state_reg != S_IDLE);
    assign status.fill       = 6'(fill_reg);

endmodule
`default_nettype wire

/* src/text_line_folder_unit.sv */
`default_nettype none
// A byte that fits is written to the line memory straight from idle. A byte that
// closes a line starts an emission: each kept character is read back from the line
// memory into the output register, then an optional hyphen and the newline follow;
// the carried word is then moved to the line start and the next line is started.
// Input is held off meanwhile, and output stalls hold up the emission.
// Reset (rst_n, async, active low) clears control, sets line width to 63; no memory clear.
module text_line_folder_unit #(
    parameter int MAX_WIDTH = 63
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlf_cfg_if.sink     cfg,
    tlf_char_if.sink    char_in,
    tlf_out_if.source   char_out
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [5:0]             line_width_reg;
    logic [5:0]             width_eff;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [7:0]             ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [7:0]             ram_rdata;
    tlf_pkg::fold_status_t  status;

    // line width register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= tlf_pkg::LINE_WIDTH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            line_width_reg <= cfg.line_width;
        end
    end

    // clamp to the supported range
    always_comb
    begin
        if (line_width_reg < tlf_pkg::MIN_WIDTH)
        begin
            width_eff = tlf_pkg::MIN_WIDTH;
        end
        else if (line_width_reg > 6'(MAX_WIDTH))
        begin
            width_eff = 6'(MAX_WIDTH);
        end
        else
        begin
            width_eff = line_width_reg;
        end
    end

    tlf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tlf_fold_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_fold_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .width_eff (width_eff),
        .char_in   (char_in),
        .char_out  (char_out),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .status    (status)
    );

`ifndef ASSERT_OFF
    // pending line never exceeds the memory
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.fill <= 6'(MAX_WIDTH))
        else $error("fill count beyond line memory");

    // a byte that fits is stored, and in the next cycle the fill count has advanced with no emission busy
    a_store_step: assert property (@(posedge clk) disable iff (!rst_n)
        (char_in.valid && char_in.ready && (char_in.in_char != tlf_pkg::CH_NL)
         && (status.fill < width_eff))
        |=> (!status.busy && (status.fill == $past(status.fill) + 6'd1)))
        else $error("stored byte did not advance fill count");

    // a closing byte always starts an emission; checked here for a newline
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (char_in.valid && char_in.ready && (char_in.in_char == tlf_pkg::CH_NL))
        |=> status.busy)
        else $error("newline did not start emission");

    // effective width stays in range
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        (width_eff >= tlf_pkg::MIN_WIDTH) && (width_eff <= 6'(MAX_WIDTH)))
        else $error("effective line width out of range");
`endif

endmodule
`default_nettype wire
